// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/rvxu_pkg.sv =====
`timescale 1ns / 1ps

package rvxu_pkg;

    localparam int XLEN     = 64;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = 5;

    localparam logic [XLEN-1:0] RESET_PC = 64'h0000_0000_8000_0000;

    // Opcodes
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3B;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_SRA  = 3'd5;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SD   = 3'd3;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_JALR = 3'd0;

    // funct7 / funct6 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_SRA  = 6'h10;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd10;

    // Result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_WAIT    = 2'd1;
    localparam logic [1:0] STATUS_HALT    = 2'd2;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd3;

    // Pending load kinds
    localparam logic [1:0] LOAD_KIND_D  = 2'd0;
    localparam logic [1:0] LOAD_KIND_W  = 2'd1;
    localparam logic [1:0] LOAD_KIND_BU = 2'd2;

    // Access sizes in bytes
    localparam logic [3:0] SIZE_B = 4'd1;
    localparam logic [3:0] SIZE_H = 4'd2;
    localparam logic [3:0] SIZE_W = 4'd4;
    localparam logic [3:0] SIZE_D = 4'd8;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              mem_valid;
        logic              mem_write;
        logic [XLEN-1:0]   mem_address;
        logic [3:0]        mem_size;
        logic [XLEN-1:0]   mem_wdata;
        logic [1:0]        status;
        logic [XLEN-1:0]   halt_code;
        rf_wr_t            wr;
        logic              ld_issue;
        logic              ld_clear;
        logic [1:0]        ld_kind;
        logic [REG_AW-1:0] ld_dest;
    } exec_t;

endpackage

// ===== hw/rtl/rvxu_ram.sv =====
`timescale 1ns / 1ps

module rvxu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // Write one entry, read two with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== hw/rtl/rvxu_regfile.sv =====
`timescale 1ns / 1ps

module rvxu_regfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rvxu_pkg::rf_wr_t               wr,
    input  logic                           rd_en,
    input  logic [rvxu_pkg::REG_AW-1:0]    rd_addr_a,
    input  logic [rvxu_pkg::REG_AW-1:0]    rd_addr_b,
    output logic [rvxu_pkg::XLEN-1:0]      rd_data_a,
    output logic [rvxu_pkg::XLEN-1:0]      rd_data_b
);

    logic [rvxu_pkg::NUM_REGS-1:0] valid_reg;
    logic                          zero_a_reg;
    logic                          zero_b_reg;
    logic                          hit_a_reg;
    logic                          hit_b_reg;
    logic [rvxu_pkg::XLEN-1:0]     byp_reg;
    logic [rvxu_pkg::XLEN-1:0]     ram_a;
    logic [rvxu_pkg::XLEN-1:0]     ram_b;
    logic                          wr_ok;

    // Drop writes to x0
    assign wr_ok = wr.en && (wr.addr != rvxu_pkg::REG_ZERO);

    rvxu_ram #(
        .WIDTH (rvxu_pkg::XLEN),
        .DEPTH (rvxu_pkg::NUM_REGS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_ok),
        .wr_addr   (wr.addr),
        .wr_data   (wr.data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    // Track written entries; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            zero_a_reg <= 1'b1;
            zero_b_reg <= 1'b1;
            hit_a_reg  <= 1'b0;
            hit_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                zero_a_reg <= (rd_addr_a == rvxu_pkg::REG_ZERO) || !valid_reg[rd_addr_a];
                zero_b_reg <= (rd_addr_b == rvxu_pkg::REG_ZERO) || !valid_reg[rd_addr_b];
                hit_a_reg  <= wr_ok && (wr.addr == rd_addr_a);
                hit_b_reg  <= wr_ok && (wr.addr == rd_addr_b);
            end
        end
    end

    // Capture a write that lands on the same edge as the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_reg <= wr.data;
        end
    end

    assign rd_data_a = hit_a_reg  ? byp_reg :
                       zero_a_reg ? '0      : ram_a;
    assign rd_data_b = hit_b_reg  ? byp_reg :
                       zero_b_reg ? '0      : ram_b;

endmodule

// ===== hw/rtl/rvxu_exec.sv =====
`timescale 1ns / 1ps

module rvxu_exec (
    input  logic                           action,
    input  logic [31:0]                    instruction,
    input  logic [rvxu_pkg::XLEN-1:0]      load_data,
    input  logic [rvxu_pkg::XLEN-1:0]      pc,
    input  logic [rvxu_pkg::XLEN-1:0]      src_a,
    input  logic [rvxu_pkg::XLEN-1:0]      src_b,
    input  logic                           load_pending,
    input  logic [1:0]                     load_kind,
    input  logic [rvxu_pkg::REG_AW-1:0]    load_dest,
    output rvxu_pkg::exec_t                ex
);

    logic [6:0]                     op;
    logic [2:0]                     f3;
    logic [6:0]                     f7;
    logic [rvxu_pkg::REG_AW-1:0]    rd;
    logic [rvxu_pkg::XLEN-1:0]      imm_i;
    logic [rvxu_pkg::XLEN-1:0]      imm_s;
    logic [rvxu_pkg::XLEN-1:0]      imm_u;
    logic [rvxu_pkg::XLEN-1:0]      imm_j;
    logic [rvxu_pkg::XLEN-1:0]      imm_b;
    logic [rvxu_pkg::XLEN-1:0]      pc_plus4;
    logic [rvxu_pkg::XLEN-1:0]      a_plus_i;
    logic [rvxu_pkg::XLEN-1:0]      a_plus_b;
    logic [31:0]                    sum_w_i;
    logic [31:0]                    sum_w_r;
    logic [rvxu_pkg::XLEN-1:0]      ld_value;

    // Split the word into fields and immediates
    assign op    = instruction[6:0];
    assign f3    = instruction[14:12];
    assign f7    = instruction[31:25];
    assign rd    = instruction[11:7];
    assign imm_i = {{52{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{52{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_u = {{32{instruction[31]}}, instruction[31:12], 12'b0};
    assign imm_j = {{43{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign imm_b = {{51{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};

    // Adders; pc_plus4 and a_plus_i are shared between instructions
    assign pc_plus4 = pc + 64'd4;
    assign a_plus_i = src_a + imm_i;
    assign a_plus_b = src_a + src_b;
    assign sum_w_i  = src_a[31:0] + imm_i[31:0];
    assign sum_w_r  = src_a[31:0] + src_b[31:0];

    // Shape returned load data by kind
    always_comb
    begin
        unique case (load_kind)
            rvxu_pkg::LOAD_KIND_W:  ld_value = {{32{load_data[31]}}, load_data[31:0]};
            rvxu_pkg::LOAD_KIND_BU: ld_value = {56'b0, load_data[7:0]};
            default:                ld_value = load_data;
        endcase
    end

    // Decode and execute in priority order
    always_comb
    begin
        ex             = '0;
        ex.next_pc     = pc_plus4;
        ex.status      = rvxu_pkg::STATUS_DONE;
        ex.wr.addr     = rd;
        ex.ld_kind     = load_kind;
        ex.ld_dest     = load_dest;

        priority if (action)
        begin
            ex.next_pc = pc;
            if (load_pending)
            begin
                ex.wr.en   = 1'b1;
                ex.wr.addr = load_dest;
                ex.wr.data = ld_value;
                ex.ld_clear = 1'b1;
            end
        end
        else if (load_pending)
        begin
            ex.next_pc = pc;
            ex.status  = rvxu_pkg::STATUS_WAIT;
        end
        else if (op == rvxu_pkg::OP_AUIPC)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = pc + imm_u;
        end
        else if (op == rvxu_pkg::OP_LOAD && (f3 == rvxu_pkg::F3_LD || f3 == rvxu_pkg::F3_LW
                 || f3 == rvxu_pkg::F3_LBU))
        begin
            ex.mem_valid   = 1'b1;
            ex.mem_address = a_plus_i;
            ex.status      = rvxu_pkg::STATUS_WAIT;
            ex.ld_issue    = 1'b1;
            ex.ld_dest     = rd;
            if (f3 == rvxu_pkg::F3_LD)
            begin
                ex.mem_size = rvxu_pkg::SIZE_D;
                ex.ld_kind  = rvxu_pkg::LOAD_KIND_D;
            end
            else if (f3 == rvxu_pkg::F3_LW)
            begin
                ex.mem_size = rvxu_pkg::SIZE_W;
                ex.ld_kind  = rvxu_pkg::LOAD_KIND_W;
            end
            else
            begin
                ex.mem_size = rvxu_pkg::SIZE_B;
                ex.ld_kind  = rvxu_pkg::LOAD_KIND_BU;
            end
        end
        else if (op == rvxu_pkg::OP_STORE && (f3 == rvxu_pkg::F3_SD || f3 == rvxu_pkg::F3_SH))
        begin
            ex.mem_valid   = 1'b1;
            ex.mem_write   = 1'b1;
            ex.mem_address = src_a + imm_s;
            if (f3 == rvxu_pkg::F3_SD)
            begin
                ex.mem_size  = rvxu_pkg::SIZE_D;
                ex.mem_wdata = src_b;
            end
            else
            begin
                ex.mem_size  = rvxu_pkg::SIZE_H;
                ex.mem_wdata = {48'b0, src_b[15:0]};
            end
        end
        else if (instruction == rvxu_pkg::EBREAK_WORD)
        begin
            ex.status    = rvxu_pkg::STATUS_HALT;
            ex.halt_code = src_a;
        end
        else if (op == rvxu_pkg::OP_REG && f3 == rvxu_pkg::F3_ADD && f7 == rvxu_pkg::F7_BASE)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = a_plus_b;
        end
        else if (op == rvxu_pkg::OP_REG && f3 == rvxu_pkg::F3_ADD && f7 == rvxu_pkg::F7_ALT)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = src_a - src_b;
        end
        else if (op == rvxu_pkg::OP_REG && f3 == rvxu_pkg::F3_SLTU && f7 == rvxu_pkg::F7_BASE)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = {63'b0, (src_a < src_b)};
        end
        else if (op == rvxu_pkg::OP_IMM && f3 == rvxu_pkg::F3_ADD)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = a_plus_i;
        end
        else if (op == rvxu_pkg::OP_IMM && f3 == rvxu_pkg::F3_SLTU)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = {63'b0, (src_a < imm_i)};
        end
        else if (op == rvxu_pkg::OP_IMM && f3 == rvxu_pkg::F3_SRA
                 && instruction[31:26] == rvxu_pkg::F6_SRA)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = $signed(src_a) >>> instruction[25:20];
        end
        else if (op == rvxu_pkg::OP_IMM32 && f3 == rvxu_pkg::F3_ADD)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = {{32{sum_w_i[31]}}, sum_w_i};
        end
        else if (op == rvxu_pkg::OP_REG32 && f3 == rvxu_pkg::F3_ADD
                 && f7 == rvxu_pkg::F7_BASE)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = {{32{sum_w_r[31]}}, sum_w_r};
        end
        else if (op == rvxu_pkg::OP_JAL)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = pc_plus4;
            ex.next_pc = pc + imm_j;
        end
        else if (op == rvxu_pkg::OP_JALR && f3 == rvxu_pkg::F3_JALR)
        begin
            ex.wr.en   = 1'b1;
            ex.wr.data = pc_plus4;
            ex.next_pc = {a_plus_i[63:1], 1'b0};
        end
        else if (op == rvxu_pkg::OP_BRANCH && f3 == rvxu_pkg::F3_BEQ)
        begin
            if (src_a == src_b)
            begin
                ex.next_pc = pc + imm_b;
            end
        end
        else if (op == rvxu_pkg::OP_BRANCH && f3 == rvxu_pkg::F3_BNE)
        begin
            if (src_a != src_b)
            begin
                ex.next_pc = pc + imm_b;
            end
        end
        else
        begin
            ex.status = rvxu_pkg::STATUS_ILLEGAL;
        end

        // Discard writes to x0
        if (ex.wr.addr == rvxu_pkg::REG_ZERO)
        begin
            ex.wr.en = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/rv64i_subset_execute_unit.sv =====
`timescale 1ns / 1ps

// RV64I subset execute unit.
// Input channel (in_valid/in_ready) carries one item: an instruction word to
// execute at the current PC (action 0) or the data for a pending load
// (action 1). Output channel (out_valid/out_ready) returns one result per
// item: next PC, an optional memory request, status and halt code.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes reset_pc; it
// is always ready.
// Path: an accepted item goes into the input register, then is executed into
// the result register, which drives the outputs.
// Throughput: one item per cycle while results are taken. The register file
// read is registered at accept time and a write landing on the same edge is
// forwarded, so dependent instructions run back to back.
// Reset: register file reads as zero, PC = 0x8000_0000, no load pending,
// both pipeline registers empty.
// Output stall: the result register holds; the input register still takes
// one more item and then in_ready drops until the result is taken.
module rv64i_subset_execute_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rvxu_pkg::XLEN-1:0]  cfg_data,
    // input items
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [31:0]                instruction,
    input  logic [rvxu_pkg::XLEN-1:0]  load_data,
    // result items
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rvxu_pkg::XLEN-1:0]  next_pc,
    output logic                       mem_valid,
    output logic                       mem_write,
    output logic [rvxu_pkg::XLEN-1:0]  mem_address,
    output logic [3:0]                 mem_size,
    output logic [rvxu_pkg::XLEN-1:0]  mem_wdata,
    output logic [1:0]                 status,
    output logic [rvxu_pkg::XLEN-1:0]  halt_code
);

    logic                           in_valid_reg;
    logic                           action_reg;
    logic [31:0]                    instruction_reg;
    logic [rvxu_pkg::XLEN-1:0]      load_data_reg;

    logic [rvxu_pkg::XLEN-1:0]      reset_pc_reg;
    logic [rvxu_pkg::XLEN-1:0]      pc_reg;
    logic                           load_pending_reg;
    logic [1:0]                     load_kind_reg;
    logic [rvxu_pkg::REG_AW-1:0]    load_dest_reg;

    logic                           out_valid_reg;
    logic [rvxu_pkg::XLEN-1:0]      next_pc_reg;
    logic                           mem_valid_reg;
    logic                           mem_write_reg;
    logic [rvxu_pkg::XLEN-1:0]      mem_address_reg;
    logic [3:0]                     mem_size_reg;
    logic [rvxu_pkg::XLEN-1:0]      mem_wdata_reg;
    logic [1:0]                     status_reg;
    logic [rvxu_pkg::XLEN-1:0]      halt_code_reg;

    logic                           in_fire;
    logic                           advance;
    logic [rvxu_pkg::REG_AW-1:0]    rd_addr_a;
    logic [rvxu_pkg::XLEN-1:0]      src_a;
    logic [rvxu_pkg::XLEN-1:0]      src_b;
    rvxu_pkg::rf_wr_t               rf_wr;
    rvxu_pkg::exec_t                ex;

    // Handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ebreak reads a0 on port A; its rs1 field is x0
    assign rd_addr_a = (instruction == rvxu_pkg::EBREAK_WORD) ? rvxu_pkg::REG_A0
                                                              : instruction[19:15];

    // Commit register writes only when the item advances
    always_comb
    begin
        rf_wr    = ex.wr;
        rf_wr.en = ex.wr.en && advance;
    end

    rvxu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rf_wr),
        .rd_en     (in_fire),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (instruction[24:20]),
        .rd_data_a (src_a),
        .rd_data_b (src_b)
    );

    rvxu_exec u_exec (
        .action       (action_reg),
        .instruction  (instruction_reg),
        .load_data    (load_data_reg),
        .pc           (pc_reg),
        .src_a        (src_a),
        .src_b        (src_b),
        .load_pending (load_pending_reg),
        .load_kind    (load_kind_reg),
        .load_dest    (load_dest_reg),
        .ex           (ex)
    );

    // Control state: input/output occupancy, PC, pending load, config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            reset_pc_reg     <= rvxu_pkg::RESET_PC;
            pc_reg           <= rvxu_pkg::RESET_PC;
            load_pending_reg <= 1'b0;
            load_kind_reg    <= rvxu_pkg::LOAD_KIND_D;
            load_dest_reg    <= rvxu_pkg::REG_ZERO;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                reset_pc_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                pc_reg <= ex.next_pc;
                if (ex.ld_issue)
                begin
                    load_pending_reg <= 1'b1;
                    load_kind_reg    <= ex.ld_kind;
                    load_dest_reg    <= ex.ld_dest;
                end
                else if (ex.ld_clear)
                begin
                    load_pending_reg <= 1'b0;
                end
            end
        end
    end

    // Payload: capture item, hold result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg      <= action;
            instruction_reg <= instruction;
            load_data_reg   <= load_data;
        end
        if (advance)
        begin
            next_pc_reg     <= ex.next_pc;
            mem_valid_reg   <= ex.mem_valid;
            mem_write_reg   <= ex.mem_write;
            mem_address_reg <= ex.mem_address;
            mem_size_reg    <= ex.mem_size;
            mem_wdata_reg   <= ex.mem_wdata;
            status_reg      <= ex.status;
            halt_code_reg   <= ex.halt_code;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign mem_valid   = mem_valid_reg;
    assign mem_write   = mem_write_reg;
    assign mem_address = mem_address_reg;
    assign mem_size    = mem_size_reg;
    assign mem_wdata   = mem_wdata_reg;
    assign status      = status_reg;
    assign halt_code   = halt_code_reg;

endmodule

// ===== hw/rtl/rvxu_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rvxu_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [rvxu_pkg::XLEN-1:0]  next_pc,
    input  logic                       mem_valid,
    input  logic                       mem_write,
    input  logic [rvxu_pkg::XLEN-1:0]  mem_address,
    input  logic [3:0]                 mem_size,
    input  logic [rvxu_pkg::XLEN-1:0]  mem_wdata,
    input  logic [1:0]                 status,
    input  logic [rvxu_pkg::XLEN-1:0]  halt_code
);

    // Request fields stay clear when no request is issued
    `ASSERT_IMPLY(a_idle_mem_clear, clk, rst_n, out_valid && !mem_valid, mem_write == 1'b0 && mem_address == '0 && mem_size == 4'd0 && mem_wdata == '0)

    // A load request always reports waiting and carries a legal size
    `ASSERT_IMPLY(a_load_waits, clk, rst_n, out_valid && mem_valid && !mem_write, status == rvxu_pkg::STATUS_WAIT && mem_wdata == '0 && (mem_size == rvxu_pkg::SIZE_B || mem_size == rvxu_pkg::SIZE_W || mem_size == rvxu_pkg::SIZE_D))

    // Halt code only on ebreak
    `ASSERT_IMPLY(a_halt_code, clk, rst_n, out_valid && status != rvxu_pkg::STATUS_HALT, halt_code == '0)

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(next_pc) && $stable(status))

    // Keep the input open while no result is waiting
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind rv64i_subset_execute_unit rvxu_checker u_checker (.*);
